FILE: rtl/point_segment_distance_defines.svh
// Assertion macros for the point_segment_distance block.
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
// condition a implies condition c in the same cycle
`define PSD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
// condition must never hold
`define PSD_ASSERT_NEVER(lbl, clk, rst_n, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("forbidden condition seen");
`else
`define PSD_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define PSD_ASSERT_NEVER(lbl, clk, rst_n, a)
`endif
`endif

FILE: rtl/psd_pkg.sv
// Shared constants and types for the point-to-segment distance pipeline.
package psd_pkg;

  localparam int DIV_STEPS = 32;          // fraction bits of projection weight
  localparam int KQ_W      = DIV_STEPS + 1;
  localparam int DIST_W    = 33;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic valid;
    logic ok;      // segment nondegenerate and 0 <= k <= 1
  } psd_ctl_t;

endpackage

FILE: rtl/point_segment_distance.sv
// Top level: point to line segment distance, fully pipelined.
//
// Channel   Direction  Ports                                    Handshake
// input     in         in_px in_py in_ax in_ay in_bx in_by_coord start, busy
// result    out        out_dist_res out_on_segment              out_valid strobe
//
// One item enters every cycle; busy stays low. Each item passes through the
// front stages, the 32-step divider pipeline, stages D to G, the square-root
// pipeline and the output register.
// Reset (rst_n low, synchronous) clears only the valid bits; data regs are free.
// The receiver cannot stall, so the pipeline never holds an item.
`include "point_segment_distance_defines.svh"
module point_segment_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      in_px,
  input  logic signed [COORD_WIDTH-1:0]      in_py,
  input  logic signed [COORD_WIDTH-1:0]      in_ax,
  input  logic signed [COORD_WIDTH-1:0]      in_ay,
  input  logic signed [COORD_WIDTH-1:0]      in_bx,
  input  logic signed [COORD_WIDTH-1:0]      in_by_coord,
  output logic                               out_valid,
  output logic [psd_pkg::DIST_W-1:0]         out_dist_res,
  output logic                               out_on_segment
);
  import psd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int RB = W + 3;        // root bits
  localparam int SW = 2 * RB;       // radicand bits

  // front -> divider
  psd_ctl_t          f_ctl;
  logic              f_eq;
  logic [2*W+2:0]    f_num;
  logic [2*W+1:0]    f_den;
  logic signed [W:0] f_dx, f_dy, f_vx, f_vy;

  // divider -> offset stages
  psd_ctl_t          d_ctl;
  logic [KQ_W-1:0]   d_kq;
  logic signed [W:0] d_dx, d_dy, d_vx, d_vy;

  // sqrt output
  psd_ctl_t          q_ctl;
  logic [RB-1:0]     q_root;

  assign busy = 1'b0;

  psd_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .px       (in_px),
    .py       (in_py),
    .ax       (in_ax),
    .ay       (in_ay),
    .bx       (in_bx),
    .by_coord (in_by_coord),
    .ctl_o    (f_ctl),
    .eq_o     (f_eq),
    .num_o    (f_num),
    .den_o    (f_den),
    .dx_o     (f_dx),
    .dy_o     (f_dy),
    .vx_o     (f_vx),
    .vy_o     (f_vy)
  );

  psd_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (f_ctl),
    .eq_i  (f_eq),
    .num_i (f_num),
    .den_i (f_den),
    .dx_i  (f_dx),
    .dy_i  (f_dy),
    .vx_i  (f_vx),
    .vy_i  (f_vy),
    .ctl_o (d_ctl),
    .kq_o  (d_kq),
    .dx_o  (d_dx),
    .dy_o  (d_dy),
    .vx_o  (d_vx),
    .vy_o  (d_vy)
  );

  // stage D: offset e = k * d (k has 32 fraction bits)
  logic                   vd_r, okd_r;
  logic signed [W+34:0]   exd_r, eyd_r;
  logic signed [W:0]      vxd_r, vyd_r;
  logic signed [KQ_W:0]   kq_s;

  // stage E: residual r = v - floor(e)
  logic                   ve_r, oke_r;
  logic signed [W+3:0]    rx_r, ry_r;
  logic signed [W+2:0]    ex_fl, ey_fl;

  // stage F: squares
  logic                   vf_r, okf_r;
  logic signed [2*W+7:0]  sqx_r, sqy_r;

  // stage G: radicand
  psd_ctl_t               g_ctl_r;
  logic [SW-1:0]          s_r;

  // output stage
  logic                   vo_r, on_r;
  logic [DIST_W-1:0]      dist_r;
  logic [DIST_W-1:0]      dist_nxt;

  always_comb begin
    kq_s  = {1'b0, d_kq};
    ex_fl = exd_r[W+34:DIV_STEPS];
    ey_fl = eyd_r[W+34:DIV_STEPS];
    // saturate; cannot trigger for COORD_WIDTH up to 32 but keeps the format closed
    if (64'(q_root) > 64'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = DIST_W'(q_root);
    end
  end

  always_ff @(posedge clk) begin
    g_ctl_r.ok <= okf_r;
    if (!rst_n) begin
      vd_r          <= 1'b0;
      ve_r          <= 1'b0;
      vf_r          <= 1'b0;
      g_ctl_r.valid <= 1'b0;
      vo_r          <= 1'b0;
    end else begin
      vd_r          <= d_ctl.valid;
      ve_r          <= vd_r;
      vf_r          <= ve_r;
      g_ctl_r.valid <= vf_r;
      vo_r          <= q_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    okd_r      <= d_ctl.ok;
    exd_r      <= kq_s * d_dx;
    eyd_r      <= kq_s * d_dy;
    vxd_r      <= d_vx;
    vyd_r      <= d_vy;

    oke_r      <= okd_r;
    rx_r       <= {{3{vxd_r[W]}}, vxd_r} - {ex_fl[W+2], ex_fl};
    ry_r       <= {{3{vyd_r[W]}}, vyd_r} - {ey_fl[W+2], ey_fl};

    okf_r      <= oke_r;
    sqx_r      <= rx_r * rx_r;
    sqy_r      <= ry_r * ry_r;

    s_r        <= sqx_r[SW-1:0] + sqy_r[SW-1:0];

    on_r       <= q_ctl.valid && q_ctl.ok;
    dist_r     <= q_ctl.ok ? dist_nxt : '0;
  end

  psd_sqrt #(.W(W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (g_ctl_r),
    .s_i    (s_r),
    .ctl_o  (q_ctl),
    .root_o (q_root)
  );

  assign out_valid      = vo_r;
  assign out_dist_res   = dist_r;
  assign out_on_segment = on_r;

  // off-segment or rejected items report zero distance
  `PSD_ASSERT_IMP(a_off_zero, clk, rst_n, out_valid && !out_on_segment, out_dist_res == '0)
  // flag only rides with a valid result
  `PSD_ASSERT_IMP(a_flag_valid, clk, rst_n, !out_valid, !out_on_segment)
  // pipeline never pushes back
  `PSD_ASSERT_NEVER(a_no_busy, clk, rst_n, busy)

endmodule

FILE: rtl/psd_front.sv
// Front stages: differences, dot products, numerator/denominator and range check.
module psd_front #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   px,
  input  logic signed [W-1:0]   py,
  input  logic signed [W-1:0]   ax,
  input  logic signed [W-1:0]   ay,
  input  logic signed [W-1:0]   bx,
  input  logic signed [W-1:0]   by_coord,
  output psd_pkg::psd_ctl_t     ctl_o,
  output logic                  eq_o,
  output logic [2*W+2:0]        num_o,
  output logic [2*W+1:0]        den_o,
  output logic signed [W:0]     dx_o,
  output logic signed [W:0]     dy_o,
  output logic signed [W:0]     vx_o,
  output logic signed [W:0]     vy_o
);
  import psd_pkg::*;

  // stage A
  logic              va_r;
  logic signed [W:0] dx_a_r, dy_a_r, vx_a_r, vy_a_r;
  // stage B
  logic                  vb_r;
  logic signed [W:0]     dx_b_r, dy_b_r, vx_b_r, vy_b_r;
  logic signed [2*W+1:0] pvx_r, pvy_r, dxx_r, dyy_r;
  // stage C
  logic                  vc_r, ok_r, eq_r;
  logic [2*W+2:0]        num_r;
  logic [2*W+1:0]        den_r;
  logic signed [W:0]     dx_c_r, dy_c_r, vx_c_r, vy_c_r;

  logic [2*W+2:0] num_nxt;
  logic [2*W+1:0] den_nxt;
  logic           ok_nxt;

  always_comb begin
    num_nxt = {pvx_r[2*W+1], pvx_r} + {pvy_r[2*W+1], pvy_r};
    den_nxt = {1'b0, dxx_r[2*W:0]} + {1'b0, dyy_r[2*W:0]};
    ok_nxt  = (den_nxt != '0) && !num_nxt[2*W+2] && !(num_nxt > {1'b0, den_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_a_r <= {bx[W-1], bx} - {ax[W-1], ax};
    dy_a_r <= {by_coord[W-1], by_coord} - {ay[W-1], ay};
    vx_a_r <= {bx[W-1], bx} - {px[W-1], px};
    vy_a_r <= {by_coord[W-1], by_coord} - {py[W-1], py};

    dx_b_r <= dx_a_r;
    dy_b_r <= dy_a_r;
    vx_b_r <= vx_a_r;
    vy_b_r <= vy_a_r;
    pvx_r  <= vx_a_r * dx_a_r;
    pvy_r  <= vy_a_r * dy_a_r;
    dxx_r  <= dx_a_r * dx_a_r;
    dyy_r  <= dy_a_r * dy_a_r;

    num_r  <= num_nxt;
    den_r  <= den_nxt;
    ok_r   <= ok_nxt;
    eq_r   <= (num_nxt == {1'b0, den_nxt});
    dx_c_r <= dx_b_r;
    dy_c_r <= dy_b_r;
    vx_c_r <= vx_b_r;
    vy_c_r <= vy_b_r;
  end

  assign ctl_o.valid = vc_r;
  assign ctl_o.ok    = ok_r;
  assign eq_o  = eq_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign dx_o  = dx_c_r;
  assign dy_o  = dy_c_r;
  assign vx_o  = vx_c_r;
  assign vy_o  = vy_c_r;

endmodule

FILE: rtl/psd_div.sv
// Pipelined restoring divider: one quotient bit of k per stage.
module psd_div #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psd_pkg::psd_ctl_t          ctl_i,
  input  logic                       eq_i,
  input  logic [2*W+2:0]             num_i,
  input  logic [2*W+1:0]             den_i,
  input  logic signed [W:0]          dx_i,
  input  logic signed [W:0]          dy_i,
  input  logic signed [W:0]          vx_i,
  input  logic signed [W:0]          vy_i,
  output psd_pkg::psd_ctl_t          ctl_o,
  output logic [psd_pkg::KQ_W-1:0]   kq_o,
  output logic signed [W:0]          dx_o,
  output logic signed [W:0]          dy_o,
  output logic signed [W:0]          vx_o,
  output logic signed [W:0]          vy_o
);
  import psd_pkg::*;

  // index 0 is the stage input, index j holds the item after j steps
  psd_ctl_t              ctl_r [0:DIV_STEPS];
  logic                  eq_r  [0:DIV_STEPS];
  logic [2*W+2:0]        rem_r [0:DIV_STEPS];
  logic [2*W+1:0]        den_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]  q_r   [0:DIV_STEPS];
  logic signed [W:0]     dx_r  [0:DIV_STEPS];
  logic signed [W:0]     dy_r  [0:DIV_STEPS];
  logic signed [W:0]     vx_r  [0:DIV_STEPS];
  logic signed [W:0]     vy_r  [0:DIV_STEPS];

  assign ctl_r[0] = ctl_i;
  assign eq_r[0]  = eq_i;
  assign rem_r[0] = num_i;
  assign den_r[0] = den_i;
  assign q_r[0]   = '0;
  assign dx_r[0]  = dx_i;
  assign dy_r[0]  = dy_i;
  assign vx_r[0]  = vx_i;
  assign vy_r[0]  = vy_i;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [2*W+2:0] sh;
    logic           ge;

    always_comb begin
      sh = {rem_r[j][2*W+1:0], 1'b0};
      ge = (sh >= {1'b0, den_r[j]});
    end

    // control word: only the valid bit is reset
    always_ff @(posedge clk) begin
      ctl_r[j+1].ok <= ctl_r[j].ok;
      if (!rst_n) begin
        ctl_r[j+1].valid <= 1'b0;
      end else begin
        ctl_r[j+1].valid <= ctl_r[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      eq_r[j+1]     <= eq_r[j];
      rem_r[j+1]    <= ge ? (sh - {1'b0, den_r[j]}) : sh;
      den_r[j+1]    <= den_r[j];
      q_r[j+1]      <= {q_r[j][DIV_STEPS-2:0], ge};
      dx_r[j+1]     <= dx_r[j];
      dy_r[j+1]     <= dy_r[j];
      vx_r[j+1]     <= vx_r[j];
      vy_r[j+1]     <= vy_r[j];
    end
  end

  // k exactly one is not reachable by the bit loop
  assign kq_o  = eq_r[DIV_STEPS] ? {1'b1, {DIV_STEPS{1'b0}}}
                                 : {1'b0, q_r[DIV_STEPS]};
  assign ctl_o = ctl_r[DIV_STEPS];
  assign dx_o  = dx_r[DIV_STEPS];
  assign dy_o  = dy_r[DIV_STEPS];
  assign vx_o  = vx_r[DIV_STEPS];
  assign vy_o  = vy_r[DIV_STEPS];

endmodule

FILE: rtl/psd_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module psd_sqrt #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psd_pkg::psd_ctl_t    ctl_i,
  input  logic [2*W+5:0]       s_i,
  output psd_pkg::psd_ctl_t    ctl_o,
  output logic [W+2:0]         root_o
);
  import psd_pkg::*;

  localparam int RB = W + 3;
  localparam int SW = 2 * RB;

  psd_ctl_t      ctl_r  [0:RB];
  logic [RB+1:0] rem_r  [0:RB];
  logic [RB-1:0] root_r [0:RB];
  logic [SW-1:0] sv_r   [0:RB];

  assign ctl_r[0]  = ctl_i;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign sv_r[0]   = s_i;

  for (genvar j = 0; j < RB; j++) begin : g_step
    logic [RB+1:0] rem_c;
    logic [RB+1:0] trial;
    logic          ge;

    always_comb begin
      rem_c = {rem_r[j][RB-1:0], sv_r[j][SW-1 -: 2]};
      trial = {root_r[j], 2'b01};
      ge    = (rem_c >= trial);
    end

    // control word: only the valid bit is reset
    always_ff @(posedge clk) begin
      ctl_r[j+1].ok <= ctl_r[j].ok;
      if (!rst_n) begin
        ctl_r[j+1].valid <= 1'b0;
      end else begin
        ctl_r[j+1].valid <= ctl_r[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j+1]    <= ge ? (rem_c - trial) : rem_c;
      root_r[j+1]   <= {root_r[j][RB-2:0], ge};
      sv_r[j+1]     <= {sv_r[j][SW-3:0], 2'b00};
    end
  end

  assign ctl_o  = ctl_r[RB];
  assign root_o = root_r[RB];

endmodule
